// File: hdl/arpr_pkg.sv
// Shared types, constants and the reply byte layout of the ARP responder.
`timescale 1ns / 1ps
`default_nettype none
package arpr_pkg;

   localparam int ARP_FRAME_BYTES = 42;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int COUNT_W = 6;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 48;
   localparam int RSP_TDATA_W = 64;

   typedef logic [COUNT_W-1:0] count_type;

   localparam count_type FRAME_BYTES_C = count_type'(ARP_FRAME_BYTES);
   localparam count_type LAST_IDX = FRAME_BYTES_C - 6'd1;

   // Byte offsets of the ARP frame fields, destination MAC at zero.
   localparam count_type OFS_SRC_MAC = 6'd6;
   localparam count_type OFS_MID = 6'd12;
   localparam count_type OFS_OPCODE = 6'd20;
   localparam count_type OFS_SND_MAC = 6'd22;
   localparam count_type OFS_SND_IP = 6'd28;
   localparam count_type OFS_TGT_MAC = 6'd32;
   localparam count_type OFS_TGT_IP = 6'd38;

   localparam logic [15:0] OPCODE_REQUEST = 16'h0001;
   localparam logic [15:0] OPCODE_REPLY = 16'h0002;

   localparam logic [47:0] OWN_MAC_RESET = 48'h0;
   localparam logic [31:0] OWN_IP_RESET = 32'h0A00_0079;
   localparam logic [31:0] PEER_IP_ZERO_RESET = 32'h0A00_006F;
   localparam logic [31:0] PEER_IP_ONE_RESET = 32'h0A00_0065;
   localparam logic [31:0] PEER_IP_TWO_RESET = 32'h0A00_0166;

   typedef enum logic {
      KIND_REPLY = 1'b0,
      KIND_LEARN = 1'b1
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OWN_MAC      = 3'd0,
      CSR_OWN_IP       = 3'd1,
      CSR_PEER_IP_ZERO = 3'd2,
      CSR_PEER_IP_ONE  = 3'd3,
      CSR_PEER_IP_TWO  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [47:0]      own_mac;
      logic [31:0]      own_ip;
      logic [2:0][31:0] peer_ip;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [47:0] src_mac;
      logic [63:0] mid;
      logic [47:0] snd_mac;
      logic [31:0] snd_ip;
      logic [2:0]  hit;
   } cmd_type;

   // Byte idx of the reply frame built from a captured request.
   function automatic logic [7:0] reply_byte(cmd_type cmd, cfg_type cfg, count_type idx);
      count_type  rel;
      logic [7:0] b;
      rel = '0;
      b = '0;
      if (idx < OFS_SRC_MAC) begin
         rel = OFS_SRC_MAC - 6'd1 - idx;
         b = cmd.src_mac[{rel[2:0], 3'b000} +: 8];
      end else if (idx < OFS_MID) begin
         rel = OFS_MID - 6'd1 - idx;
         b = cfg.own_mac[{rel[2:0], 3'b000} +: 8];
      end else if (idx < OFS_OPCODE) begin
         rel = OFS_OPCODE - 6'd1 - idx;
         b = cmd.mid[{rel[2:0], 3'b000} +: 8];
      end else if (idx == OFS_OPCODE) begin
         b = OPCODE_REPLY[15:8];
      end else if (idx < OFS_SND_MAC) begin
         b = OPCODE_REPLY[7:0];
      end else if (idx < OFS_SND_IP) begin
         rel = OFS_SND_IP - 6'd1 - idx;
         b = cfg.own_mac[{rel[2:0], 3'b000} +: 8];
      end else if (idx < OFS_TGT_MAC) begin
         rel = OFS_TGT_MAC - 6'd1 - idx;
         b = cfg.own_ip[{rel[1:0], 3'b000} +: 8];
      end else if (idx < OFS_TGT_IP) begin
         rel = OFS_TGT_IP - 6'd1 - idx;
         b = cmd.snd_mac[{rel[2:0], 3'b000} +: 8];
      end else begin
         rel = LAST_IDX - idx;
         b = cmd.snd_ip[{rel[1:0], 3'b000} +: 8];
      end
      return b;
   endfunction

endpackage
`default_nettype wire

// File: hdl/arpr_front.sv
// Receive side: captures ARP fields byte by byte and classifies the finished frame.
`timescale 1ns / 1ps
`default_nettype none
module arpr_front import arpr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   input  wire logic [7:0] req_tdata,
   input  wire logic    req_tlast,
   input  wire cfg_type cfg,
   output logic         push_valid,
   output cmd_type      push_cmd,
   input  wire logic    push_ready
);

   count_type   count_ff;
   logic        done_ff;
   logic        full_ff;
   logic [47:0] src_mac_ff;
   logic [63:0] mid_ff;
   logic [15:0] opcode_ff;
   logic [47:0] snd_mac_ff;
   logic [31:0] snd_ip_ff;
   logic [31:0] tgt_ip_ff;

   logic       accept;
   logic [2:0] hit;
   logic       target_ok;
   logic       is_request;
   logic       is_learn;

   assign req_tready = !done_ff;
   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff <= 1'b0;
         full_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (req_tlast) begin
               count_ff <= '0;
               done_ff <= 1'b1;
               full_ff <= (count_ff >= LAST_IDX);
            end else if (count_ff < FRAME_BYTES_C) begin
               count_ff <= count_ff + 6'd1;
            end
         end else if (done_ff && (!push_valid || push_ready)) begin
            done_ff <= 1'b0;
         end
      end
   end

   // Each captured field shifts in while the byte counter walks over its offsets.
   always_ff @(posedge clock) begin
      if (accept) begin
         if (count_ff >= OFS_SRC_MAC && count_ff < OFS_MID) begin
            src_mac_ff <= {src_mac_ff[39:0], req_tdata};
         end
         if (count_ff >= OFS_MID && count_ff < OFS_OPCODE) begin
            mid_ff <= {mid_ff[55:0], req_tdata};
         end
         if (count_ff >= OFS_OPCODE && count_ff < OFS_SND_MAC) begin
            opcode_ff <= {opcode_ff[7:0], req_tdata};
         end
         if (count_ff >= OFS_SND_MAC && count_ff < OFS_SND_IP) begin
            snd_mac_ff <= {snd_mac_ff[39:0], req_tdata};
         end
         if (count_ff >= OFS_SND_IP && count_ff < OFS_TGT_MAC) begin
            snd_ip_ff <= {snd_ip_ff[23:0], req_tdata};
         end
         if (count_ff >= OFS_TGT_IP && count_ff < FRAME_BYTES_C) begin
            tgt_ip_ff <= {tgt_ip_ff[23:0], req_tdata};
         end
      end
   end

   always_comb begin
      hit[0] = (snd_ip_ff == cfg.peer_ip[0]);
      hit[1] = (snd_ip_ff == cfg.peer_ip[1]);
      hit[2] = (snd_ip_ff == cfg.peer_ip[2]);
      target_ok = full_ff && (tgt_ip_ff == cfg.own_ip);
      is_request = (opcode_ff == OPCODE_REQUEST);
      is_learn = (opcode_ff == OPCODE_REPLY) && (hit != 3'b000);
      push_valid = done_ff && target_ok && (is_request || is_learn);
      push_cmd.kind = is_request ? KIND_REPLY : KIND_LEARN;
      push_cmd.src_mac = src_mac_ff;
      push_cmd.mid = mid_ff;
      push_cmd.snd_mac = snd_mac_ff;
      push_cmd.snd_ip = snd_ip_ff;
      push_cmd.hit = hit;
   end

endmodule
`default_nettype wire

// File: hdl/arpr_queue.sv
// Small command queue between the receive side and the result sequencer.
`timescale 1ns / 1ps
`default_nettype none
module arpr_queue import arpr_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire cmd_type push_cmd,
   output logic         push_ready,
   output logic         pop_valid,
   output cmd_type      pop_cmd,
   input  wire logic    pop_ready
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   logic do_push;
   logic do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// File: hdl/arpr_back.sv
// Result sequencer: walks a command out as reply bytes or one learn result.
`timescale 1ns / 1ps
`default_nettype none
module arpr_back import arpr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    pop_valid,
   input  wire cmd_type pop_cmd,
   output logic         pop_ready,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic         rsp_tuser,
   output logic         rsp_tlast
);

   count_type               idx_ff;
   logic                    rsp_valid_ff;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff;
   logic                    rsp_user_ff;
   logic                    rsp_last_ff;

   logic                    slot_free;
   logic                    fire;
   logic                    cmd_end;
   logic [7:0]              next_byte;
   logic [2:0]              next_hit;
   logic [47:0]             next_mac;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign fire = pop_valid && slot_free;
   assign cmd_end = (pop_cmd.kind == KIND_LEARN) || (idx_ff == LAST_IDX);
   assign pop_ready = fire && cmd_end;

   always_comb begin
      if (pop_cmd.kind == KIND_LEARN) begin
         next_byte = 8'h00;
         next_hit = pop_cmd.hit;
         next_mac = pop_cmd.snd_mac;
      end else begin
         next_byte = reply_byte(pop_cmd, cfg, idx_ff);
         next_hit = 3'b000;
         next_mac = 48'h0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            idx_ff <= cmd_end ? '0 : idx_ff + 6'd1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= {5'b00000, next_mac, next_hit, next_byte};
         rsp_user_ff <= pop_cmd.kind;
         rsp_last_ff <= cmd_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
   assign rsp_tlast = rsp_last_ff;

endmodule
`default_nettype wire

// File: hdl/arp_responder_peer_learn.sv
// Top level of the ARP responder with peer learning: registers and the two halves.
//
// Channel  Dir  Handshake          Payload
// req      in   req_tvalid/tready  tdata[7:0] rx_byte, tlast rx_last
// rsp      out  rsp_tvalid/tready  tdata[7:0] tx_byte, [10:8] peer_hit,
//                                  [58:11] learned_mac; tuser result_kind; tlast tx_last
// csr      in   csr_valid/ready    csr_index register, csr_data value
//
// Bytes are taken one per cycle while req_tready is high; after the last byte of each
// frame the receive side drops req_tready while it checks the frame, and holds it low
// while a command for that frame waits on a full command queue.
// Results go out one per cycle unless stalled; a reply is 42 results, a learn is one.
// The command queue lets a new frame come in while a reply is still going out.
// Reset is synchronous; there is no clearing pass after it.
`timescale 1ns / 1ps
`default_nettype none
module arp_responder_peer_learn import arpr_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [7:0]              req_tdata,   // [7:0] rx_byte
   input  wire logic                    req_tlast,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,   // [7:0] tx_byte, [10:8] peer_hit,
                                                     // [58:11] learned_mac, rest zero
   output logic                         rsp_tuser,   // [0] result_kind
   output logic                         rsp_tlast,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_data
);

   cfg_type cfg_ff;
   cmd_type push_cmd;
   cmd_type pop_cmd;
   logic    push_valid;
   logic    push_ready;
   logic    pop_valid;
   logic    pop_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_mac <= OWN_MAC_RESET;
         cfg_ff.own_ip <= OWN_IP_RESET;
         cfg_ff.peer_ip[0] <= PEER_IP_ZERO_RESET;
         cfg_ff.peer_ip[1] <= PEER_IP_ONE_RESET;
         cfg_ff.peer_ip[2] <= PEER_IP_TWO_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_OWN_MAC:      cfg_ff.own_mac <= csr_data;
            CSR_OWN_IP:       cfg_ff.own_ip <= csr_data[31:0];
            CSR_PEER_IP_ZERO: cfg_ff.peer_ip[0] <= csr_data[31:0];
            CSR_PEER_IP_ONE:  cfg_ff.peer_ip[1] <= csr_data[31:0];
            CSR_PEER_IP_TWO:  cfg_ff.peer_ip[2] <= csr_data[31:0];
            default: begin
            end
         endcase
      end
   end

   arpr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   arpr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   arpr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// File: hdl/arpr_checker.sv
// Port-level checks on the result channel of the ARP responder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module arpr_checker import arpr_pkg::*; (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                   rsp_tuser,
   input wire logic                   rsp_tlast
);

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A learn result stands alone and always closes its frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("learn result without tlast");

   // A learn result names at least one peer slot and carries no frame byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[10:8] != 3'b000) && (rsp_tdata[7:0] == 8'h00))
      else $error("malformed learn result");

   // A reply byte carries no peer information.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata[RSP_TDATA_W-1:8] == '0))
      else $error("reply byte with peer fields set");

endmodule

bind arp_responder_peer_learn arpr_checker u_arpr_checker (.*);
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the ARP responder with peer learning.
`timescale 1ns / 1ps
module testbench;
   import arpr_pkg::*;

   localparam int HOLD_CYCLES = 500;
   localparam int SETTLE_CYCLES = 50;
   localparam int ROW_COUNT = 20;
   localparam int CFG_SWITCH_ROW = 15;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_UNUSED = 3'd7;

   typedef enum int {SND_PEER_ZERO, SND_PEER_ONE, SND_PEER_TWO, SND_OTHER} snd_sel_type;
   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  tx_byte;
      logic [2:0]  hit;
      logic [47:0] mac;
      logic        last;
   } arp_result_type;

   typedef struct {
      logic [15:0] opcode;
      bit          tgt_own;
      snd_sel_type snd_sel;
      fill_type    fill;
      int          len;
      int          n_results;
      logic [2:0]  hit;
   } frame_row_type;

   // Directed frames; the result counts and hit masks follow from the register
   // values in force (reset values first, then the all-ones/all-zeros set).
   frame_row_type directed [ROW_COUNT] = '{
      '{OPCODE_REQUEST, 1'b1, SND_OTHER,     FILL_RANDOM, 42,  42, 3'b000},
      '{OPCODE_REPLY,   1'b1, SND_PEER_ZERO, FILL_RANDOM, 42,  1,  3'b001},
      '{OPCODE_REPLY,   1'b1, SND_PEER_ONE,  FILL_ZERO,   42,  1,  3'b010},
      '{OPCODE_REPLY,   1'b1, SND_PEER_TWO,  FILL_ONES,   42,  1,  3'b100},
      '{OPCODE_REPLY,   1'b1, SND_OTHER,     FILL_RANDOM, 42,  0,  3'b000},
      '{OPCODE_REQUEST, 1'b1, SND_OTHER,     FILL_RANDOM, 41,  0,  3'b000},
      '{OPCODE_REQUEST, 1'b1, SND_OTHER,     FILL_RANDOM, 1,   0,  3'b000},
      '{OPCODE_REQUEST, 1'b0, SND_OTHER,     FILL_RANDOM, 42,  0,  3'b000},
      '{16'h0000,       1'b1, SND_OTHER,     FILL_RANDOM, 42,  0,  3'b000},
      '{16'h0003,       1'b1, SND_OTHER,     FILL_RANDOM, 42,  0,  3'b000},
      '{16'h0101,       1'b1, SND_OTHER,     FILL_RANDOM, 42,  0,  3'b000},
      '{16'hFFFF,       1'b1, SND_OTHER,     FILL_ONES,   42,  0,  3'b000},
      '{OPCODE_REQUEST, 1'b1, SND_OTHER,     FILL_RANDOM, 100, 42, 3'b000},
      '{OPCODE_REQUEST, 1'b1, SND_OTHER,     FILL_ZERO,   42,  42, 3'b000},
      '{OPCODE_REQUEST, 1'b1, SND_OTHER,     FILL_ONES,   42,  42, 3'b000},
      '{OPCODE_REQUEST, 1'b1, SND_OTHER,     FILL_ZERO,   42,  42, 3'b000},
      '{OPCODE_REPLY,   1'b1, SND_PEER_ZERO, FILL_RANDOM, 42,  1,  3'b011},
      '{OPCODE_REPLY,   1'b1, SND_PEER_TWO,  FILL_ONES,   42,  1,  3'b100},
      '{OPCODE_REQUEST, 1'b0, SND_OTHER,     FILL_ONES,   42,  0,  3'b000},
      '{OPCODE_REPLY,   1'b1, SND_OTHER,     FILL_RANDOM, 42,  0,  3'b000}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_OWN_MAC;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Responder state as the testbench sees it.
   logic [47:0] own_mac_q = OWN_MAC_RESET;
   logic [31:0] own_ip_q = OWN_IP_RESET;
   logic [31:0] peer_ip_q [3] = '{PEER_IP_ZERO_RESET, PEER_IP_ONE_RESET, PEER_IP_TWO_RESET};
   logic [47:0] peer_mac_q [3] = '{48'h0, 48'h0, 48'h0};
   logic [7:0] rx_buf [ARP_FRAME_BYTES];
   int rx_count = 0;

   arp_result_type pending_results[$];
   int predicted_total = 0;
   logic [2:0] last_learn_hit = '0;
   logic [7:0] frame_bytes[$];

   int fail_count = 0;
   bit req_idle_en = 1'b0;
   bit rsp_idle_en = 1'b0;
   bit hold_req = 1'b0;
   int hold_left = 0;
   int stall_left = 0;

   arp_responder_peer_learn u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report(input string msg);
      $display("MISMATCH at %0t ns: %s", $time, msg);
      fail_count++;
   endtask

   function automatic logic [47:0] rand48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[47:0];
   endfunction

   function automatic void push_result(input kind_type k, input logic [7:0] b,
                                       input logic [2:0] h, input logic [47:0] m,
                                       input logic l);
      arp_result_type r;
      r.kind = k;
      r.tx_byte = b;
      r.hit = h;
      r.mac = m;
      r.last = l;
      pending_results.push_back(r);
      predicted_total++;
   endfunction

   function automatic void csr_apply(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] d);
      case (idx)
         CSR_OWN_MAC:      own_mac_q = d;
         CSR_OWN_IP:       own_ip_q = d[31:0];
         CSR_PEER_IP_ZERO: peer_ip_q[0] = d[31:0];
         CSR_PEER_IP_ONE:  peer_ip_q[1] = d[31:0];
         CSR_PEER_IP_TWO:  peer_ip_q[2] = d[31:0];
         default: ;
      endcase
   endfunction

   // Takes one accepted frame byte and queues whatever the responder should send.
   function automatic void arp_rx_byte(input logic [7:0] b, input logic l);
      int n;
      int k;
      logic [31:0] tgt_ip;
      logic [31:0] snd_ip;
      logic [47:0] snd_mac;
      logic [15:0] op;
      logic [2:0] hit;
      logic [7:0] reply [ARP_FRAME_BYTES];
      if (rx_count < ARP_FRAME_BYTES) begin
         rx_buf[rx_count] = b;
         rx_count++;
      end
      if (!l) return;
      n = rx_count;
      rx_count = 0;
      if (n < ARP_FRAME_BYTES) return;
      tgt_ip = {rx_buf[OFS_TGT_IP], rx_buf[OFS_TGT_IP + 1], rx_buf[OFS_TGT_IP + 2],
                rx_buf[OFS_TGT_IP + 3]};
      if (tgt_ip != own_ip_q) return;
      op = {rx_buf[OFS_OPCODE], rx_buf[OFS_OPCODE + 1]};
      snd_ip = '0;
      snd_mac = '0;
      for (k = 0; k < 4; k++) snd_ip = {snd_ip[23:0], rx_buf[OFS_SND_IP + k]};
      for (k = 0; k < 6; k++) snd_mac = {snd_mac[39:0], rx_buf[OFS_SND_MAC + k]};
      if (op == OPCODE_REQUEST) begin
         for (k = 0; k < ARP_FRAME_BYTES; k++) reply[k] = rx_buf[k];
         for (k = 0; k < 6; k++) begin
            reply[k] = rx_buf[OFS_SRC_MAC + k];
            reply[OFS_SRC_MAC + k] = own_mac_q[47 - 8 * k -: 8];
            reply[OFS_SND_MAC + k] = own_mac_q[47 - 8 * k -: 8];
            reply[OFS_TGT_MAC + k] = rx_buf[OFS_SND_MAC + k];
         end
         for (k = 0; k < 4; k++) begin
            reply[OFS_SND_IP + k] = own_ip_q[31 - 8 * k -: 8];
            reply[OFS_TGT_IP + k] = rx_buf[OFS_SND_IP + k];
         end
         reply[OFS_OPCODE] = OPCODE_REPLY[15:8];
         reply[OFS_OPCODE + 1] = OPCODE_REPLY[7:0];
         for (k = 0; k < ARP_FRAME_BYTES; k++)
            push_result(KIND_REPLY, reply[k], 3'b000, 48'h0, k == ARP_FRAME_BYTES - 1);
      end else if (op == OPCODE_REPLY) begin
         hit = '0;
         for (k = 0; k < 3; k++) begin
            if (snd_ip == peer_ip_q[k]) begin
               peer_mac_q[k] = snd_mac;
               hit[k] = 1'b1;
            end
         end
         if (hit != '0) begin
            last_learn_hit = hit;
            push_result(KIND_LEARN, 8'h00, hit, snd_mac, 1'b1);
         end
      end
   endfunction

   // Target IP is own IP or its complement, so a mismatch is certain.
   function automatic void build_frame(input logic [15:0] op, input bit tgt_own,
                                       input snd_sel_type sel, input fill_type fill,
                                       input int len);
      int k;
      logic [31:0] tgt_ip;
      frame_bytes.delete();
      for (k = 0; k < ((len > ARP_FRAME_BYTES) ? len : ARP_FRAME_BYTES); k++) begin
         if (fill == FILL_ZERO) frame_bytes.push_back(8'h00);
         else if (fill == FILL_ONES) frame_bytes.push_back(8'hFF);
         else frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
      tgt_ip = tgt_own ? own_ip_q : ~own_ip_q;
      frame_bytes[OFS_OPCODE] = op[15:8];
      frame_bytes[OFS_OPCODE + 1] = op[7:0];
      for (k = 0; k < 4; k++) begin
         frame_bytes[OFS_TGT_IP + k] = tgt_ip[31 - 8 * k -: 8];
         if (sel != SND_OTHER)
            frame_bytes[OFS_SND_IP + k] = peer_ip_q[int'(sel)][31 - 8 * k -: 8];
      end
      while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
   endfunction

   function automatic void rand_frame();
      int r;
      logic [15:0] op;
      int len;
      fill_type fill;
      r = $urandom_range(0, 99);
      if (r < 45) op = OPCODE_REQUEST;
      else if (r < 85) op = OPCODE_REPLY;
      else op = 16'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 85) len = ARP_FRAME_BYTES;
      else if (r < 93) len = $urandom_range(1, ARP_FRAME_BYTES - 1);
      else len = $urandom_range(ARP_FRAME_BYTES + 1, 90);
      r = $urandom_range(0, 19);
      if (r == 0) fill = FILL_ZERO;
      else if (r == 1) fill = FILL_ONES;
      else fill = FILL_RANDOM;
      build_frame(op, $urandom_range(0, 9) != 0, snd_sel_type'($urandom_range(0, 3)),
                  fill, len);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic l);
      if (req_idle_en && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= l;
      do @(posedge clock); while (req_tready !== 1'b1);
      arp_rx_byte(b, l);
   endtask

   task automatic send_frame();
      int k;
      for (k = 0; k < frame_bytes.size(); k++)
         send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
   endtask

   // Stops offering requests and lets every queued result drain out.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_apply(idx, d);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Unused upper bits of the IP registers carry random junk.
   task automatic csr_write_all(input logic [47:0] mac, input logic [31:0] ip,
                                input logic [31:0] p0, input logic [31:0] p1,
                                input logic [31:0] p2);
      csr_write(CSR_OWN_MAC, mac);
      csr_write(CSR_OWN_IP, {16'($urandom), ip});
      csr_write(CSR_PEER_IP_ZERO, {16'($urandom), p0});
      csr_write(CSR_PEER_IP_ONE, {16'($urandom), p1});
      csr_write(CSR_PEER_IP_TWO, {16'($urandom), p2});
   endtask

   // Response side ready: random stall bursts plus one long hold-off on request.
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (rsp_idle_en && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
      end
   end

   always @(posedge clock) begin : rsp_check
      arp_result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected result tdata=%h tuser=%b", rsp_tdata, rsp_tuser));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.kind)
               report($sformatf("result_kind got %b want %b", rsp_tuser, want.kind));
            if (rsp_tdata[7:0] !== want.tx_byte)
               report($sformatf("tx_byte got %h want %h", rsp_tdata[7:0], want.tx_byte));
            if (rsp_tdata[10:8] !== want.hit)
               report($sformatf("peer_hit got %b want %b", rsp_tdata[10:8], want.hit));
            if (rsp_tdata[58:11] !== want.mac)
               report($sformatf("learned_mac got %h want %h", rsp_tdata[58:11], want.mac));
            if (rsp_tdata[RSP_TDATA_W-1:59] !== '0)
               report($sformatf("tdata padding not zero: %h", rsp_tdata));
            if (rsp_tlast !== want.last)
               report($sformatf("tx_last got %b want %b", rsp_tlast, want.last));
         end
      end
   end

   initial begin
      #12_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int i;
      int start_count;
      frame_row_type row;
      logic [31:0] shared_ip;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;

      for (i = 0; i < ROW_COUNT; i++) begin
         if (i == CFG_SWITCH_ROW) begin
            wait_idle();
            csr_write_all('1, '1, '0, '0, '1);
            csr_write(CSR_INDEX_UNUSED, rand48());
         end
         row = directed[i];
         start_count = predicted_total;
         build_frame(row.opcode, row.tgt_own, row.snd_sel, row.fill, row.len);
         send_frame();
         if (predicted_total - start_count != row.n_results)
            report($sformatf("frame %0d: %0d results predicted, table says %0d", i,
                             predicted_total - start_count, row.n_results));
         if (row.n_results == 1 && last_learn_hit != row.hit)
            report($sformatf("frame %0d: hit %b predicted, table says %b", i,
                             last_learn_hit, row.hit));
      end

      // Peer slots zero and two share one address, so a learn can hit both.
      wait_idle();
      shared_ip = $urandom;
      csr_write_all(rand48(), $urandom, shared_ip, $urandom, shared_ip);
      repeat (40) begin
         rand_frame();
         send_frame();
      end

      // Keep requests coming while the result side holds off, so the input backs up.
      wait_idle();
      req_idle_en = 1'b0;
      hold_req = 1'b1;
      repeat (6) begin
         build_frame(OPCODE_REQUEST, 1'b1, SND_OTHER, FILL_RANDOM, ARP_FRAME_BYTES);
         send_frame();
      end
      wait_idle();

      csr_write_all(rand48(), '0, $urandom, $urandom, $urandom);
      req_idle_en = 1'b1;
      repeat (40) begin
         rand_frame();
         send_frame();
      end
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      repeat (20) begin
         rand_frame();
         send_frame();
      end
      wait_idle();

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/arpr_pkg.sv
hdl/arpr_front.sv
hdl/arpr_queue.sv
hdl/arpr_back.sv
hdl/arp_responder_peer_learn.sv
hdl/arpr_checker.sv
tb/sv/testbench.sv
